### hw/rtl/bseg_pkg.sv
// Shared types and constants for the button scan event generator.
`timescale 1ns / 1ps

package bseg_pkg;

  // Number of switch inputs that are scanned; higher switch bits are ignored.
  localparam int NUM_BUTTONS = 8;
  localparam logic [7:0] BUTTON_MASK =
    8'(((32'd1 << NUM_BUTTONS) - 32'd1) & 32'h0000_00FF);

  // Configuration register indexes (word address bits [3:2]).
  localparam logic [1:0] REG_USE_SHIFT    = 2'd0;
  localparam logic [1:0] REG_SHIFT_BIT    = 2'd1;
  localparam logic [1:0] REG_REPEAT_DELAY = 2'd2;

  // Configuration reset values.
  localparam logic       USE_SHIFT_RST    = 1'b1;
  localparam logic [2:0] SHIFT_BIT_RST    = 3'd0;
  localparam logic [7:0] REPEAT_DELAY_RST = 8'd20;

  // Indicator thresholds: on below ON_LIMIT, off above OFF_LIMIT, age saturates.
  localparam logic [2:0] IND_ON_LIMIT  = 3'd2;
  localparam logic [2:0] IND_OFF_LIMIT = 3'd4;
  localparam logic [2:0] IND_AGE_MAX   = 3'd7;
  localparam logic [7:0] CHANGE_AGE_MAX = 8'hFF;

  typedef enum logic [2:0] {
    EV_BUTTONS      = 3'd0,
    EV_MIDI_IN_ON   = 3'd1,
    EV_MIDI_IN_OFF  = 3'd2,
    EV_MIDI_OUT_ON  = 3'd3,
    EV_MIDI_OUT_OFF = 3'd4
  } event_kind_t;

  // One scan tick word.
  typedef struct packed {
    logic [7:0] raw_switches;
    logic       midi_in_flash;
    logic       midi_out_flash;
  } scan_word_t;

  // One event word.
  typedef struct packed {
    event_kind_t event_kind;
    logic [7:0]  pressed_mask;
    logic        is_repeat;
    logic        last_of_tick;
  } event_word_t;

endpackage

### hw/rtl/button_scan_event_generator.sv
// Button scan event generator: change detect, autorepeat and MIDI indicators.
`timescale 1ns / 1ps

// Channel   Direction  Word          Handshake
// in_       input      scan_word_t   in_valid / in_ready
// out_      output     event_word_t  out_valid / out_ready
// config    APB slave  32-bit data   psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// A scan word is evaluated in the cycle it is accepted and its zero to three
// events are captured in a pending set; one event moves per cycle into the
// output register while the output is not stalled, and the next word is taken
// in the cycle the last pending event moves out (or at once if none is pending).
// Reset is synchronous and clears configuration, scan state, pending flags and
// output valid; the payload registers are not reset. A stalled output holds its
// word and back-pressures the input while the pending set is still occupied.
module button_scan_event_generator (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  bseg_pkg::scan_word_t   in_word,
  output logic                   out_valid,
  input  logic                   out_ready,
  output bseg_pkg::event_word_t  out_word,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import bseg_pkg::*;

  // Indicator evaluation result.
  typedef struct packed {
    logic       turn_on;
    logic       turn_off;
    logic       lit;
    logic [2:0] age;
  } ind_res_t;

  function automatic ind_res_t ind_eval(input logic lit, input logic [2:0] age,
                                        input logic flash);
    ind_res_t   r;
    logic [2:0] a;
    a          = flash ? 3'd0 : age;
    r.turn_on  = !lit && (a < IND_ON_LIMIT);
    r.turn_off = lit && (a > IND_OFF_LIMIT);
    r.lit      = r.turn_on ? 1'b1 : (r.turn_off ? 1'b0 : lit);
    r.age      = (a < IND_AGE_MAX) ? a + 3'd1 : IND_AGE_MAX;
    return r;
  endfunction

  // Configuration registers.
  logic       use_shift_r;
  logic [2:0] shift_bit_r;
  logic [7:0] repeat_delay_r;

  // Scan state.
  logic [7:0] prev_pressed_r;
  logic [7:0] change_age_r;
  logic       tick_parity_r;
  logic       in_lit_r, out_lit_r;
  logic [2:0] in_age_r, out_age_r;

  // Pending event set: slot 0 button, slot 1 MIDI in, slot 2 MIDI out.
  logic [2:0] pend_v_r, pend_v_nxt;
  logic [7:0] pend_mask_r;
  logic       pend_rep_r;
  logic       pend_in_off_r;
  logic       pend_out_off_r;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  event_word_t out_word_r, out_word_nxt;

  logic        accept, load_out, cfg_wr;
  logic [2:0]  sel_oh, remain;
  logic [7:0]  buttons, shift_mask, diff, age;
  logic        changed, shift_only, btn_ev;
  ind_res_t    ind_in, ind_out;

  // Tick evaluation.
  always_comb begin
    buttons    = ~in_word.raw_switches & BUTTON_MASK;
    shift_mask = 8'(8'd1 << shift_bit_r);
    diff       = buttons ^ prev_pressed_r;
    changed    = diff != 8'd0;
    shift_only = buttons == shift_mask;
    age        = changed ? 8'd0 : change_age_r;
    if (changed && buttons != 8'd0) begin
      btn_ev = (!use_shift_r || !shift_only) &&
               (!shift_only || (diff & shift_mask) != 8'd0);
    end else begin
      btn_ev = (buttons != 8'd0) && !shift_only && (age > repeat_delay_r) &&
               !tick_parity_r;
    end
    ind_in  = ind_eval(in_lit_r, in_age_r, in_word.midi_in_flash);
    ind_out = ind_eval(out_lit_r, out_age_r, in_word.midi_out_flash);
  end

  // Pick the lowest pending slot and work out whether it ends the tick.
  always_comb begin
    case (1'b1)
      pend_v_r[0]: sel_oh = 3'b001;
      pend_v_r[1]: sel_oh = 3'b010;
      pend_v_r[2]: sel_oh = 3'b100;
      default:     sel_oh = 3'b000;
    endcase
    remain   = pend_v_r & ~sel_oh;
    load_out = (pend_v_r != 3'b000) && (!out_valid_r || out_ready);
    in_ready = (pend_v_r == 3'b000) || (load_out && remain == 3'b000);
    accept   = in_valid && in_ready;
  end

  // Next pending set and output word.
  always_comb begin
    pend_v_nxt = load_out ? remain : pend_v_r;
    if (accept) begin
      pend_v_nxt = {ind_out.turn_on || ind_out.turn_off,
                    ind_in.turn_on || ind_in.turn_off, btn_ev};
    end
    out_word_nxt              = out_word_r;
    out_word_nxt.pressed_mask = 8'd0;
    out_word_nxt.is_repeat    = 1'b0;
    out_word_nxt.last_of_tick = remain == 3'b000;
    case (sel_oh)
      3'b001: begin
        out_word_nxt.event_kind   = EV_BUTTONS;
        out_word_nxt.pressed_mask = pend_mask_r;
        out_word_nxt.is_repeat    = pend_rep_r;
      end
      3'b010: begin
        out_word_nxt.event_kind = pend_in_off_r ? EV_MIDI_IN_OFF : EV_MIDI_IN_ON;
      end
      3'b100: begin
        out_word_nxt.event_kind = pend_out_off_r ? EV_MIDI_OUT_OFF : EV_MIDI_OUT_ON;
      end
      default: begin
        out_word_nxt = out_word_r;
      end
    endcase
    if (!load_out) begin
      out_word_nxt = out_word_r;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Configuration write strobe and read mux.
  always_comb begin
    cfg_wr = psel && penable && pwrite;
    case (paddr[3:2])
      REG_USE_SHIFT:    prdata = {31'd0, use_shift_r};
      REG_SHIFT_BIT:    prdata = {29'd0, shift_bit_r};
      REG_REPEAT_DELAY: prdata = {24'd0, repeat_delay_r};
      default:          prdata = 32'd0;
    endcase
  end

  assign pready    = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_shift_r    <= USE_SHIFT_RST;
      shift_bit_r    <= SHIFT_BIT_RST;
      repeat_delay_r <= REPEAT_DELAY_RST;
      prev_pressed_r <= 8'd0;
      change_age_r   <= 8'd0;
      tick_parity_r  <= 1'b0;
      in_lit_r       <= 1'b0;
      out_lit_r      <= 1'b0;
      in_age_r       <= 3'd0;
      out_age_r      <= 3'd0;
      pend_v_r       <= 3'b000;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_USE_SHIFT:    use_shift_r    <= pwdata[0];
          REG_SHIFT_BIT:    shift_bit_r    <= pwdata[2:0];
          REG_REPEAT_DELAY: repeat_delay_r <= pwdata[7:0];
          default:          ;
        endcase
      end
      if (accept) begin
        prev_pressed_r <= buttons;
        change_age_r   <= (age < CHANGE_AGE_MAX) ? age + 8'd1 : CHANGE_AGE_MAX;
        tick_parity_r  <= !tick_parity_r;
        in_lit_r       <= ind_in.lit;
        in_age_r       <= ind_in.age;
        out_lit_r      <= ind_out.lit;
        out_age_r      <= ind_out.age;
      end
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_mask_r    <= buttons;
      pend_rep_r     <= !changed;
      pend_in_off_r  <= ind_in.turn_off;
      pend_out_off_r <= ind_out.turn_off;
    end
    out_word_r <= out_word_nxt;
  end

endmodule

### tb/sv/tb_button_scan_event_generator.sv
// Self-checking testbench for the button scan event generator.
`timescale 1ns / 1ps

module tb_button_scan_event_generator;
  import bseg_pkg::*;

  // Register index with no register behind it; a write there must be ignored.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // Predicts the event words of each accepted scan word and checks the output.
  class event_scoreboard;
    logic        use_shift;
    logic [2:0]  shift_bit;
    logic [7:0]  repeat_delay;
    logic [7:0]  prev_pressed;
    logic [7:0]  age_since_change;
    logic        tick_parity;
    logic        in_lit;
    logic        out_lit;
    logic [2:0]  in_age;
    logic [2:0]  out_age;
    event_word_t expected_q[$];
    event_word_t tick_ev[3];
    int          tick_n;
    int          errors;

    function new();
      use_shift        = USE_SHIFT_RST;
      shift_bit        = SHIFT_BIT_RST;
      repeat_delay     = REPEAT_DELAY_RST;
      prev_pressed     = 8'h00;
      age_since_change = 8'h00;
      tick_parity      = 1'b0;
      in_lit           = 1'b0;
      out_lit          = 1'b0;
      in_age           = 3'd0;
      out_age          = 3'd0;
      errors           = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_USE_SHIFT: begin
          use_shift = value[0];
        end
        REG_SHIFT_BIT: begin
          shift_bit = value[2:0];
        end
        REG_REPEAT_DELAY: begin
          repeat_delay = value[7:0];
        end
        default: begin
        end
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void add_tick_event(event_kind_t kind, logic [7:0] mask, logic rep);
      tick_ev[tick_n].event_kind   = kind;
      tick_ev[tick_n].pressed_mask = mask;
      tick_ev[tick_n].is_repeat    = rep;
      tick_ev[tick_n].last_of_tick = 1'b0;
      tick_n++;
    endfunction

    // One activity lamp: turns on while young, off once old, age saturates.
    function void lamp_step(inout logic lit, inout logic [2:0] age, input logic flash,
                            output logic went_on, output logic went_off);
      logic [2:0] a;
      a = flash ? 3'd0 : age;
      went_on  = 1'b0;
      went_off = 1'b0;
      if (!lit && a < IND_ON_LIMIT) begin
        lit     = 1'b1;
        went_on = 1'b1;
      end else if (lit && a > IND_OFF_LIMIT) begin
        lit      = 1'b0;
        went_off = 1'b1;
      end
      age = (a < IND_AGE_MAX) ? a + 3'd1 : IND_AGE_MAX;
    endfunction

    function void note_scan(scan_word_t w);
      logic [7:0] buttons;
      logic [7:0] shift_mask;
      logic [7:0] diff;
      logic [7:0] age;
      logic       changed;
      logic       shift_only;
      logic       went_on;
      logic       went_off;
      tick_n     = 0;
      buttons    = ~w.raw_switches & BUTTON_MASK;
      shift_mask = 8'd1 << shift_bit;
      diff       = buttons ^ prev_pressed;
      changed    = diff != 8'h00;
      shift_only = buttons == shift_mask;
      age        = changed ? 8'h00 : age_since_change;

      // A fresh combination, unless shift alone: shift rule on or shift unchanged.
      if (changed && buttons != 8'h00) begin
        if ((!use_shift || !shift_only) && (!shift_only || (diff & shift_mask) != 8'h00)) begin
          add_tick_event(EV_BUTTONS, buttons, 1'b0);
        end
      end else if (buttons != 8'h00 && !shift_only) begin
        if (age > repeat_delay && !tick_parity) begin
          add_tick_event(EV_BUTTONS, buttons, 1'b1);
        end
      end

      lamp_step(in_lit, in_age, w.midi_in_flash, went_on, went_off);
      if (went_on) begin
        add_tick_event(EV_MIDI_IN_ON, 8'h00, 1'b0);
      end else if (went_off) begin
        add_tick_event(EV_MIDI_IN_OFF, 8'h00, 1'b0);
      end
      lamp_step(out_lit, out_age, w.midi_out_flash, went_on, went_off);
      if (went_on) begin
        add_tick_event(EV_MIDI_OUT_ON, 8'h00, 1'b0);
      end else if (went_off) begin
        add_tick_event(EV_MIDI_OUT_OFF, 8'h00, 1'b0);
      end

      if (tick_n > 0) begin
        tick_ev[tick_n - 1].last_of_tick = 1'b1;
      end
      for (int i = 0; i < tick_n; i++) begin
        expected_q.push_back(tick_ev[i]);
      end

      prev_pressed     = buttons;
      age_since_change = (age < CHANGE_AGE_MAX) ? age + 8'd1 : CHANGE_AGE_MAX;
      tick_parity      = ~tick_parity;
    endfunction

    function void check_event(event_word_t got);
      event_word_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected event word: kind %0d mask %02h repeat %0b last %0b",
               got.event_kind, got.pressed_mask, got.is_repeat, got.last_of_tick);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.event_kind !== want.event_kind) begin
        $error("event_kind: expected %0d, got %0d", want.event_kind, got.event_kind);
        errors++;
      end
      if (got.pressed_mask !== want.pressed_mask) begin
        $error("pressed_mask: expected %02h, got %02h", want.pressed_mask, got.pressed_mask);
        errors++;
      end
      if (got.is_repeat !== want.is_repeat) begin
        $error("is_repeat: expected %0b, got %0b", want.is_repeat, got.is_repeat);
        errors++;
      end
      if (got.last_of_tick !== want.last_of_tick) begin
        $error("last_of_tick: expected %0b, got %0b", want.last_of_tick, got.last_of_tick);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  scan_word_t  in_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  event_word_t out_word;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  event_scoreboard sb = new();
  int              events_seen = 0;

  button_scan_event_generator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 0;
  end

  // Mostly short gaps, now and then a long one, often none at all.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic flash_bit();
    return $urandom_range(0, 9) < 3;
  endfunction

  // Button combinations weighted toward the shift rules and releases.
  function automatic logic [7:0] pick_pressed();
    logic [7:0] shift_mask;
    int         r;
    shift_mask = 8'd1 << sb.shift_bit;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'h00;
    if (r < 40) return shift_mask;
    if (r < 55) return shift_mask | (8'd1 << $urandom_range(0, 7));
    return 8'($urandom_range(1, 255));
  endfunction

  // Register write: setup cycle, access cycle, then the bus is left idle.
  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.write_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one scan word and returns at the edge that accepts it.
  task automatic send_scan(input logic [7:0] raw, input logic fin, input logic fout);
    scan_word_t w;
    w.raw_switches   = raw;
    w.midi_in_flash  = fin;
    w.midi_out_flash = fout;
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_scan(w);
  endtask

  task automatic sender_pause(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drains every expected event, then lets a word with no events finish too.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Output monitor: every accepted event word is checked against the prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_event(out_word);
      events_seen++;
    end
  end

  // Event sink: random stalls, plus one long hold-off that backs up the input.
  initial begin : event_sink
    int  n;
    bit  long_hold_done;
    long_hold_done = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (!long_hold_done && events_seen >= 30) begin
        long_hold_done = 1'b1;
        n = 200;
      end else begin
        n = pick_gap();
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [7:0] combo;
    int         run;
    int         sent;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Startup lamps, everything pressed, release to nothing, shift rule enabled.
    send_scan(8'hFF, 1'b0, 1'b0);
    send_scan(8'h00, 1'b1, 1'b1);
    send_scan(8'h00, 1'b0, 1'b0);
    send_scan(8'hFF, 1'b0, 1'b0);
    send_scan(8'hFE, 1'b0, 1'b1);
    send_scan(8'hF6, 1'b1, 1'b0);
    send_scan(8'hFE, 1'b0, 1'b0);
    repeat (5) send_scan(8'hFF, 1'b0, 1'b0);

    // Shift on the top bit, shift rule off, immediate repeats.
    settle();
    apb_write(REG_USE_SHIFT, 32'd0);
    apb_write(REG_SHIFT_BIT, 32'd7);
    apb_write(REG_REPEAT_DELAY, 32'd0);
    apb_write(REG_UNUSED, 32'hFFFF_FFFF);
    send_scan(8'h7F, 1'b0, 1'b0);
    send_scan(8'h7F, 1'b0, 1'b0);
    send_scan(8'h7E, 1'b0, 1'b0);
    send_scan(8'h7F, 1'b0, 1'b0);
    repeat (4) send_scan(8'hBD, 1'b0, 1'b0);
    send_scan(8'h7F, 1'b0, 1'b0);
    send_scan(8'hFF, 1'b1, 1'b0);

    // Long hold until the change age saturates, repeating only once it passes 254.
    settle();
    apb_write(REG_USE_SHIFT, 32'd1);
    apb_write(REG_SHIFT_BIT, 32'd0);
    apb_write(REG_REPEAT_DELAY, 32'd254);
    repeat (262) begin
      send_scan(8'h5A, flash_bit(), flash_bit());
      sender_pause(pick_gap());
    end

    // With the delay at its maximum a saturated hold never repeats.
    settle();
    apb_write(REG_REPEAT_DELAY, 32'd255);
    repeat (16) begin
      send_scan(8'h5A, flash_bit(), flash_bit());
      sender_pause(pick_gap());
    end

    // Random phases: held combinations of random length, with some noise words.
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: begin
          apb_write(REG_USE_SHIFT, 32'd1);
          apb_write(REG_SHIFT_BIT, 32'd3);
          apb_write(REG_REPEAT_DELAY, 32'd2);
        end
        1: begin
          apb_write(REG_USE_SHIFT, 32'd0);
          apb_write(REG_SHIFT_BIT, 32'd0);
          apb_write(REG_REPEAT_DELAY, 32'd0);
        end
        2: begin
          apb_write(REG_USE_SHIFT, 32'($urandom_range(0, 1)));
          apb_write(REG_SHIFT_BIT, 32'd7);
          apb_write(REG_REPEAT_DELAY, 32'd1);
        end
        default: begin
          apb_write(REG_USE_SHIFT, 32'($urandom_range(0, 1)));
          apb_write(REG_SHIFT_BIT, 32'($urandom_range(0, 7)));
          apb_write(REG_REPEAT_DELAY, 32'($urandom_range(0, 6)));
        end
      endcase
      sent = 0;
      while (sent < 45) begin
        if ($urandom_range(0, 9) == 0) begin
          send_scan(8'($urandom), flash_bit(), flash_bit());
          sent++;
          sender_pause(pick_gap());
        end else begin
          combo = pick_pressed();
          run = $urandom_range(1, 10);
          repeat (run) begin
            send_scan(~combo, flash_bit(), flash_bit());
            sent++;
            sender_pause(pick_gap());
          end
        end
      end
    end

    settle();
    if (sb.errors == 0) begin
      $display("button_scan_event_generator verification clean");
    end else begin
      $display("button_scan_event_generator verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #4_000_000;
    $display("button_scan_event_generator verification failed");
    $finish;
  end

endmodule
